// ----- hw/rtl/metropolis_rotor_chain_update_core_defines.svh -----
// Assertion macros shared by the rotor chain update block.
`ifndef METROPOLIS_ROTOR_CHAIN_UPDATE_CORE_DEFINES_SVH
`define METROPOLIS_ROTOR_CHAIN_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/mrc_pkg.sv -----
// Shared types, constants and lookup functions of the rotor chain update block.
package mrc_pkg;

  localparam int unsigned MAX_SITES_DEF = 1024;
  // Width that holds any site index or chain length up to the largest chain.
  localparam int IDX_W   = 17;
  localparam int SITE_W  = 10;
  localparam int NOISE_W = 16;
  localparam int ANG_W   = 32;
  localparam int CFG_W   = 32;
  localparam int LEN_W   = 11;
  localparam int PADDR_W = 4;

  // Digit-serial wide multiplier: A is taken 16 bits per cycle.
  localparam int MUL_DIG_W  = 16;
  localparam int MUL_DIGITS = 3;
  localparam int MUL_A_W    = MUL_DIG_W * MUL_DIGITS;
  localparam int MUL_B_W    = 34;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  // 1/(2*pi) in Q0.32.
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  typedef enum logic [1:0] {
    REG_STEP = 2'd0,
    REG_KIN  = 2'd1,
    REG_POT  = 2'd2,
    REG_LEN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] step_size;
    logic [CFG_W-1:0] kinetic_coeff;
    logic [CFG_W-1:0] potential_coeff;
    logic [LEN_W-1:0] chain_length;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  // round(2^16 * e^-n) for the integer part of the action change.
  function automatic logic [16:0] exp_int(input logic [3:0] n);
    logic [16:0] v;
    case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // floor(2^20 / k) for the small divisors of the Taylor recurrence.
  function automatic logic [20:0] recip(input logic [3:0] k);
    logic [20:0] v;
    case (k)
      4'd1:    v = 21'd1048576;
      4'd2:    v = 21'd524288;
      4'd3:    v = 21'd349525;
      4'd4:    v = 21'd262144;
      4'd5:    v = 21'd209715;
      4'd6:    v = 21'd174762;
      4'd7:    v = 21'd149796;
      4'd8:    v = 21'd131072;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/mrc_channels.sv -----
// Valid/ready channel interfaces for input words and result words.
interface mrc_in_if;
  import mrc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [SITE_W-1:0]         site;
  logic signed [NOISE_W-1:0] proposal_noise;
  logic [NOISE_W-1:0]        accept_noise;

  modport source (output valid, site, proposal_noise, accept_noise, input ready);
  modport sink   (input valid, site, proposal_noise, accept_noise, output ready);
endinterface

interface mrc_out_if;
  import mrc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SITE_W-1:0]       site_out;
  logic signed [ANG_W-1:0] angle;
  logic                    accepted;

  modport source (output valid, site_out, angle, accepted, input ready);
  modport sink   (input valid, site_out, angle, accepted, output ready);
endinterface

// ----- hw/rtl/metropolis_rotor_chain_update_core.sv -----
// Metropolis single-site update of a periodic chain of Q16.16 phase angles. After reset
// the block clears its angle memory, one entry per cycle, and takes no word until that
// pass ends. It then handles one word at a time: three reads of the angle memory (site,
// right and left neighbour), the proposal, two passes through the digit-serial
// multiplier for the kinetic term, two polynomial cosine evaluations and, when the
// action grows by less than 12, an eight-step Taylor recurrence for exp (multiply,
// divide and correct in each step, then the table product). A site beyond the chain
// skips these steps and goes straight to the result.
// The result waits in an output register, so the next word is taken while it is pending.
`include "metropolis_rotor_chain_update_core_defines.svh"

module metropolis_rotor_chain_update_core #(
  parameter int unsigned MAX_SITES = mrc_pkg::MAX_SITES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mrc_in_if.sink                      in_ch,
  mrc_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mrc_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [mrc_pkg::CFG_W-1:0]   cfg_pwdata,
  output logic [mrc_pkg::CFG_W-1:0]   cfg_prdata,
  output logic                        cfg_pready
);
  import mrc_pkg::*;

  localparam int AW = $clog2(MAX_SITES);
  localparam logic [62:0] SAT_CAP = 63'(1) << 62;

  typedef enum logic [23:0] {
    S_CLEAR = 24'h000001,
    S_IDLE  = 24'h000002,
    S_RDX   = 24'h000004,
    S_RDR   = 24'h000008,
    S_RDL   = 24'h000010,
    S_OFF   = 24'h000020,
    S_PROP  = 24'h000040,
    S_AB    = 24'h000080,
    S_KAB   = 24'h000100,
    S_KK    = 24'h000200,
    S_CANG  = 24'h000400,
    S_CT    = 24'h000800,
    S_CZ    = 24'h001000,
    S_CH1   = 24'h002000,
    S_CH2   = 24'h004000,
    S_CH3   = 24'h008000,
    S_CC    = 24'h010000,
    S_POT   = 24'h020000,
    S_DS    = 24'h040000,
    S_EMUL  = 24'h080000,
    S_EDIV  = 24'h100000,
    S_ECOR  = 24'h200000,
    S_ET    = 24'h400000,
    S_FIN   = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr, clr_addr_r;
  logic [ANG_W-1:0] ram_wdata, ram_rdata;

  // Word registers.
  logic [SITE_W-1:0]  site_r;
  logic [NOISE_W-1:0] pn_r, un_r;
  logic               inrange_r;
  logic [AW-1:0]      ri_r, li_r;
  logic signed [31:0] x_r, r_r, l_r, y_r;
  logic [47:0]        prod_r, m1_r;
  logic signed [32:0] da_r;
  logic signed [34:0] db_r;
  logic signed [47:0] kin_r;
  logic               issued_r;
  logic               csel_r, cneg_r;
  logic [61:0]        cp_r;
  logic [1:0]         q_r;
  logic [16:0]        arg_r, z_r, poly_r;
  logic signed [17:0] cx_r, cy_r;
  logic signed [34:0] pot_r;
  logic [15:0]        f_r, qv_r, est_r;
  logic [3:0]         n_r, k_r;
  logic [16:0]        eh_r;
  logic               acc_r;

  logic               out_valid_r;
  logic [SITE_W-1:0]  out_site_r;
  logic [ANG_W-1:0]   out_angle_r;
  logic               out_acc_r;

  // Chain geometry of the incoming word.
  logic [IDX_W-1:0] len, site_ext, site_inc, ri_c, li_c;
  logic             in_fire, fin_fire;

  always_comb begin
    len = IDX_W'(cfg.chain_length);
    if (len > IDX_W'(MAX_SITES)) len = IDX_W'(MAX_SITES);
    if (len < IDX_W'(3)) len = IDX_W'(3);
  end

  assign site_ext = IDX_W'(in_ch.site);
  assign site_inc = site_ext + 1'b1;
  assign ri_c     = (site_inc == len) ? '0 : site_inc;
  assign li_c     = (site_ext == '0) ? len - 1'b1 : site_ext - 1'b1;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign fin_fire    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // Proposal offset and saturated new angle.
  logic [16:0]        mn;
  logic [48:0]        step_prod, off_add;
  logic [33:0]        off_mag;
  logic signed [35:0] x_ext, off_s, y_sum;
  logic [31:0]        y_sat;

  assign mn        = pn_r[15] ? 17'h10000 - {1'b0, pn_r} : {1'b0, pn_r};
  assign step_prod = cfg.step_size * mn;
  assign off_add   = {1'b0, prod_r} + (pn_r[15] ? 49'd32767 : 49'd0);
  assign off_mag   = off_add[48:15];
  assign x_ext     = 36'(x_r);
  assign off_s     = pn_r[15] ? -$signed({2'b00, off_mag}) : $signed({2'b00, off_mag});
  assign y_sum     = x_ext + off_s;

  always_comb begin
    if (y_sum > 36'sd2147483647) y_sat = 32'h7FFF_FFFF;
    else if (y_sum < -36'sd2147483648) y_sat = 32'h8000_0000;
    else y_sat = y_sum[31:0];
  end

  // Kinetic term operands and saturation of the wide products.
  logic [32:0] da_mag;
  logic [34:0] db_abs;
  logic [62:0] psat;

  assign da_mag = da_r[32] ? 33'(-da_r) : 33'(da_r);
  assign db_abs = db_r[34] ? 35'(-db_r) : 35'(db_r);
  assign psat   = (mul_rsp.prod > MUL_P_W'(SAT_CAP)) ? SAT_CAP : mul_rsp.prod[62:0];

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = MUL_A_W'(da_mag);
    mul_req.b     = db_abs[33:0];
    if (state_r == S_KAB) begin
      mul_req.start = !issued_r;
    end else if (state_r == S_KK) begin
      mul_req.start = !issued_r;
      mul_req.a     = m1_r;
      mul_req.b     = MUL_B_W'(cfg.kinetic_coeff);
    end
  end

  // Cosine: turn phase, quadrant folding and quarter-wave polynomial.
  logic signed [31:0] cang;
  logic [31:0]        cmag;
  logic [61:0]        cprod;
  logic [63:0]        pn64;
  logic [15:0]        tph;
  logic [16:0]        xq, arg_c;
  logic [33:0]        arg_sq, zh;
  logic [22:0]        z60;
  logic signed [18:0] c_raw;
  logic [16:0]        c_clamp;
  logic signed [17:0] c_val;

  assign cang   = csel_r ? y_r : x_r;
  assign cmag   = cang[31] ? 32'(-cang) : 32'(cang);
  assign cprod  = cmag * INV_TWO_PI;
  assign pn64   = cneg_r ? 64'd0 - {2'b00, cp_r} : {2'b00, cp_r};
  assign tph    = pn64[47:32];
  assign xq     = {1'b0, tph[13:0], 2'b00};
  assign arg_c  = (tph[15:14] == 2'd0 || tph[15:14] == 2'd2) ? xq : 17'h10000 - xq;
  assign arg_sq = arg_r * arg_r;
  assign z60    = z_r * 6'd60;
  assign zh     = z_r * poly_r;
  assign c_raw  = 19'sd65536 - $signed({2'b00, zh[32:16]});
  assign c_clamp = c_raw[18] ? 17'd0 : c_raw[16:0];
  assign c_val  = (q_r == 2'd1 || q_r == 2'd2) ? -$signed({1'b0, c_clamp})
                                               : $signed({1'b0, c_clamp});

  // Potential term and action change.
  logic signed [18:0] dcos;
  logic [17:0]        dmag;
  logic [49:0]        pmul;
  logic signed [48:0] ds;

  assign dcos = 19'(cx_r) - 19'(cy_r);
  assign dmag = dcos[18] ? 18'(-dcos) : 18'(dcos);
  assign pmul = dmag * cfg.potential_coeff;
  assign ds   = 49'(kin_r) + 49'(pot_r);

  // Exponential: Taylor recurrence with reciprocal division by k.
  logic [31:0] fe;
  logic [36:0] qr;
  logic [19:0] ek, rem;
  logic [16:0] quo;
  logic [33:0] te;

  assign fe  = f_r * eh_r;
  assign qr  = qv_r * recip(k_r);
  assign ek  = est_r * k_r;
  assign rem = {4'b0000, qv_r} - ek;
  assign quo = (rem >= 20'(k_r)) ? 17'(est_r) + 1'b1 : 17'(est_r);
  assign te  = exp_int(n_r) * eh_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == AW'(MAX_SITES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) state_nxt = (site_ext >= len) ? S_FIN : S_RDX;
      end
      S_RDX:  state_nxt = S_RDR;
      S_RDR:  state_nxt = S_RDL;
      S_RDL:  state_nxt = S_OFF;
      S_OFF:  state_nxt = S_PROP;
      S_PROP: state_nxt = S_AB;
      S_AB:   state_nxt = S_KAB;
      S_KAB:  if (mul_rsp.done) state_nxt = S_KK;
      S_KK:   if (mul_rsp.done) state_nxt = S_CANG;
      S_CANG: state_nxt = S_CT;
      S_CT:   state_nxt = S_CZ;
      S_CZ:   state_nxt = S_CH1;
      S_CH1:  state_nxt = S_CH2;
      S_CH2:  state_nxt = S_CH3;
      S_CH3:  state_nxt = S_CC;
      S_CC:   state_nxt = csel_r ? S_POT : S_CANG;
      S_POT:  state_nxt = S_DS;
      S_DS: begin
        if (ds[48] || ds == '0 || ds[47:20] != '0 || ds[19:16] >= 4'd12) state_nxt = S_FIN;
        else state_nxt = S_EMUL;
      end
      S_EMUL: state_nxt = S_EDIV;
      S_EDIV: state_nxt = S_ECOR;
      S_ECOR: state_nxt = (k_r == 4'd1) ? S_ET : S_EMUL;
      S_ET:   state_nxt = S_FIN;
      S_FIN:  if (fin_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (mul_req.start) issued_r <= 1'b1;
      else if (mul_rsp.done) issued_r <= 1'b0;
      if (fin_fire) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers, loaded step by step.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        site_r    <= in_ch.site;
        pn_r      <= in_ch.proposal_noise;
        un_r      <= in_ch.accept_noise;
        inrange_r <= site_ext < len;
        ri_r      <= ri_c[AW-1:0];
        li_r      <= li_c[AW-1:0];
        acc_r     <= 1'b0;
        csel_r    <= 1'b0;
      end
      S_RDX:  x_r <= ram_rdata;
      S_RDR:  r_r <= ram_rdata;
      S_RDL:  l_r <= ram_rdata;
      S_OFF:  prod_r <= step_prod[47:0];
      S_PROP: y_r <= y_sat;
      S_AB: begin
        da_r <= 33'(x_r) - 33'(y_r);
        db_r <= 35'(r_r) + 35'(l_r) - 35'(x_r) - 35'(y_r);
      end
      S_KAB:  if (mul_rsp.done) m1_r <= psat[62:15];
      S_KK: begin
        if (mul_rsp.done) begin
          kin_r <= (da_r[32] != db_r[34]) ? -48'(psat[62:16]) : 48'(psat[62:16]);
        end
      end
      S_CANG: begin
        cp_r   <= cprod;
        cneg_r <= cang[31];
      end
      S_CT: begin
        q_r   <= tph[15:14];
        arg_r <= arg_c;
      end
      S_CZ:   z_r <= arg_sq[32:16];
      S_CH1:  poly_r <= 17'd1367 - 17'(z60[22:16]);
      S_CH2:  poly_r <= 17'd16624 - zh[32:16];
      S_CH3:  poly_r <= 17'd80852 - zh[32:16];
      S_CC: begin
        if (csel_r) cy_r <= c_val;
        else cx_r <= c_val;
        csel_r <= 1'b1;
      end
      S_POT:  pot_r <= dcos[18] ? -35'(pmul[49:16]) : 35'(pmul[49:16]);
      S_DS: begin
        // A falling or unchanged action always accepts; a large one leaves exp at zero.
        if (ds[48] || ds == '0) acc_r <= 1'b1;
        else if (ds[47:20] != '0 || ds[19:16] >= 4'd12) acc_r <= (un_r == '0);
        f_r  <= ds[15:0];
        n_r  <= ds[19:16];
        eh_r <= 17'h10000;
        k_r  <= 4'd8;
      end
      S_EMUL: qv_r <= fe[31:16];
      S_EDIV: est_r <= qr[35:20];
      S_ECOR: begin
        eh_r <= 17'h10000 - quo;
        k_r  <= k_r - 1'b1;
      end
      S_ET:   acc_r <= (te[33:16] >= 18'(un_r));
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_site_r  <= site_r;
      out_acc_r   <= acc_r && inrange_r;
      out_angle_r <= !inrange_r ? '0 : (acc_r ? y_r : x_r);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.site_out = out_site_r;
  assign out_ch.angle    = out_angle_r;
  assign out_ch.accepted = out_acc_r;

  // Memory ports: clearing pass, write-back and neighbour reads.
  assign ram_we    = (state_r == S_CLEAR) || (fin_fire && acc_r && inrange_r);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : site_r[AW-1:0];
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : y_r;

  always_comb begin
    case (state_r)
      S_RDX:   ram_raddr = ri_r;
      S_RDR:   ram_raddr = li_r;
      default: ram_raddr = site_ext[AW-1:0];
    endcase
  end

  mrc_angle_ram #(.DEPTH(MAX_SITES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mrc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  mrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Checks on the sequencer, memory and multiplier hand-off.
  `MRC_ASSERT_NOW(a_we_in_clear_or_fin, ram_we, (state_r == S_CLEAR) || (state_r == S_FIN))
  `MRC_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != S_IDLE)
  `MRC_ASSERT_NOW(a_mul_start_when_free, mul_req.start, !mul_rsp.busy)

endmodule

// ----- hw/rtl/mrc_mul.sv -----
// Digit-serial wide multiplier: one 16-bit digit of A times B per cycle.
module mrc_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  mrc_pkg::mul_req_t req,
  output mrc_pkg::mul_rsp_t rsp
);
  import mrc_pkg::*;

  localparam int DIG_CW = $clog2(MUL_DIGITS);

  logic [MUL_A_W-1:0]           a_r;
  logic [MUL_B_W-1:0]           b_r;
  logic [MUL_P_W-1:0]           acc_r;
  logic [DIG_CW-1:0]            dig_r;
  logic                         busy_r;
  logic                         done_r;
  logic [MUL_DIG_W+MUL_B_W-1:0] part;
  logic [MUL_P_W-1:0]           part_sh;

  // Partial product of the current digit, aligned to its weight.
  assign part    = a_r[dig_r*MUL_DIG_W +: MUL_DIG_W] * b_r;
  assign part_sh = MUL_P_W'(part) << (dig_r * MUL_DIG_W);

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dig_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        dig_r  <= '0;
      end else if (busy_r) begin
        if (dig_r == DIG_CW'(MUL_DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          dig_r <= dig_r + 1'b1;
        end
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + part_sh;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ----- hw/rtl/mrc_angle_ram.sv -----
// Angle store: one write port and one registered read port.
module mrc_angle_ram #(
  parameter int unsigned DEPTH = mrc_pkg::MAX_SITES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [mrc_pkg::ANG_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [mrc_pkg::ANG_W-1:0] rdata
);
  import mrc_pkg::*;

  logic [ANG_W-1:0] mem [DEPTH];
  logic [ANG_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/mrc_cfg_regs.sv -----
// APB-style configuration registers with read back.
module mrc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrc_pkg::PADDR_W-1:0] paddr,
  input  logic [mrc_pkg::CFG_W-1:0]   pwdata,
  output logic [mrc_pkg::CFG_W-1:0]   prdata,
  output logic                        pready,
  output mrc_pkg::cfg_t               cfg
);
  import mrc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size       <= 32'd65536;
      cfg_r.kinetic_coeff   <= 32'd8192;
      cfg_r.potential_coeff <= 32'd65536;
      cfg_r.chain_length    <= 11'd1024;
    end else if (wr_en) begin
      unique case (idx)
        REG_STEP: cfg_r.step_size       <= pwdata;
        REG_KIN:  cfg_r.kinetic_coeff   <= pwdata;
        REG_POT:  cfg_r.potential_coeff <= pwdata;
        REG_LEN:  cfg_r.chain_length    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_STEP: prdata = cfg_r.step_size;
      REG_KIN:  prdata = cfg_r.kinetic_coeff;
      REG_POT:  prdata = cfg_r.potential_coeff;
      REG_LEN:  prdata = CFG_W'(cfg_r.chain_length);
      default:  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
